[sv/jstm_pkg.sv]
// Shared types and constants of the job slot timer manager.
`default_nettype none

package jstm_pkg;

  localparam int NUM_SLOTS       = 16;
  localparam int TIMERS_PER_SLOT = 2;
  localparam int TIMER_BITS      = 32;

  localparam int NUM_TIMERS = NUM_SLOTS * TIMERS_PER_SLOT;
  localparam int CMD_W      = 3;
  localparam int SLOT_W     = 4;
  localparam int TIDX_W     = SLOT_W + 1;
  localparam int DUR_W      = 32;
  localparam int REG_W      = 32;
  localparam int BIT_IDX_W  = 5;
  localparam int HI_OFS     = 16;
  localparam int STATUS_W   = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_SUBMIT = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_IDLE   = 3'd0,
    ST_ACTIVE = 3'd1,
    ST_DONE   = 3'd2,
    ST_SOFT   = 3'd3,
    ST_HARD   = 3'd4
  } status_t;

  typedef struct packed {
    logic                  we;
    logic [TIDX_W-1:0]     addr;
    logic [TIMER_BITS-1:0] data;
  } timer_wr_t;

endpackage

`default_nettype wire

[sv/jstm_timer_ram.sv]
// Countdown value store for all timers, one write and one registered read port.
`default_nettype none

module jstm_timer_ram import jstm_pkg::*; (
  input  logic                  clk,
  input  timer_wr_t             wr,
  input  logic [TIDX_W-1:0]     raddr,
  output logic [TIMER_BITS-1:0] rdata
);

  logic [TIMER_BITS-1:0] mem [NUM_TIMERS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/jstm_countdown.sv]
// Shared decrement and expiry compare unit used for every timer in turn.
`default_nettype none

module jstm_countdown import jstm_pkg::*; (
  input  logic [TIMER_BITS-1:0] value,
  output logic [TIMER_BITS-1:0] value_next,
  output logic                  expired
);

  assign expired    = (value <= TIMER_BITS'(1));
  assign value_next = expired ? '0 : (value - TIMER_BITS'(1));

endmodule

`default_nettype wire

[sv/job_slot_timer_manager.sv]
// Top level of the job slot timer manager: sequencer, slot state and result register.
//
// Usage: one command transaction enters on the job channel (job_valid/job_ready)
// and exactly one result transaction leaves on the result channel
// (res_valid/res_ready), carrying the interrupt and occupancy views, the status
// of the addressed slot and the submit acceptance flag after the command acted.
// Submit, stop, clear and read pass through the EXEC and FIN states before the
// next command can be accepted; the result register is loaded from FIN.
// A tick walks all timers through one shared decrement and compare unit, with a
// read state and an update state per timer because the timer store has one
// registered read port.
// job_ready is high only while the sequencer is idle. A finished result waits in
// FIN until the output register is free; the block accepts no next command
// until the receiver takes the pending result.
// Reset clears all running flags, occupancy, interrupts and slot status and
// leaves the result channel empty; the timer store needs no clearing because a
// value is only read for a running timer.
`default_nettype none

module job_slot_timer_manager import jstm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_ready,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [DUR_W-1:0]    duration,
  input  logic                hard_stop,
  input  logic [REG_W-1:0]    clear_mask,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [REG_W-1:0]    irq_pending,
  output logic [REG_W-1:0]    occupancy,
  output logic [STATUS_W-1:0] slot_status,
  output logic                accepted
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_TRD  = 5'b00100,
    S_TUPD = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [CMD_W-1:0]      cmd_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [DUR_W-1:0]      dur_q;
  logic                  hard_q;
  logic [REG_W-1:0]      mask_q;
  logic [TIDX_W-1:0]     idx;
  logic [NUM_TIMERS-1:0] running;
  logic [REG_W-1:0]      occ_bits;
  logic [REG_W-1:0]      irq_bits;
  status_t               status_q [NUM_SLOTS];
  logic                  acc_q;

  logic                  slot_ok;
  logic [TIDX_W-1:0]     t0;
  logic [TIDX_W-1:0]     t1;
  logic [TIMER_BITS-1:0] dur_sat;
  logic [BIT_IDX_W-1:0]  lo_sub;
  logic [BIT_IDX_W-1:0]  hi_sub;
  logic [SLOT_W-1:0]     tslot;
  logic [BIT_IDX_W-1:0]  lo_tick;
  logic [BIT_IDX_W-1:0]  hi_tick;
  logic                  load_res;

  timer_wr_t             wr;
  logic [TIMER_BITS-1:0] rdata;
  logic [TIMER_BITS-1:0] cd_next;
  logic                  cd_expired;

  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  jstm_timer_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (idx),
    .rdata (rdata)
  );

  jstm_countdown u_cd (
    .value      (rdata),
    .value_next (cd_next),
    .expired    (cd_expired)
  );

  assign slot_ok = ({1'b0, slot_q} < (SLOT_W + 1)'(NUM_SLOTS));
  assign t0      = {slot_q, 1'b0};
  assign t1      = {slot_q, 1'b1};
  assign lo_sub  = BIT_IDX_W'(slot_q);
  assign hi_sub  = BIT_IDX_W'(HI_OFS) + BIT_IDX_W'(slot_q);
  assign tslot   = idx[TIDX_W-1:1];
  assign lo_tick = BIT_IDX_W'(tslot);
  assign hi_tick = BIT_IDX_W'(HI_OFS) + BIT_IDX_W'(tslot);

  always_comb begin
    if (TIMER_BITS >= DUR_W) begin
      dur_sat = TIMER_BITS'(dur_q);
    end else if (dur_q > DUR_W'(TMAX)) begin
      dur_sat = TMAX;
    end else begin
      dur_sat = TIMER_BITS'(dur_q);
    end
  end

  always_comb begin
    wr.we   = 1'b0;
    wr.addr = idx;
    wr.data = cd_next;
    if (state == S_EXEC && cmd_q == CMD_SUBMIT && slot_ok) begin
      wr.data = dur_sat;
      if (!running[t0]) begin
        wr.we   = 1'b1;
        wr.addr = t0;
      end else if (!running[t1]) begin
        wr.we   = 1'b1;
        wr.addr = t1;
      end
    end else if (state == S_TUPD) begin
      wr.we = running[idx];
    end
  end

  assign job_ready = (state == S_IDLE);
  assign load_res  = (state == S_FIN) && (!res_valid || res_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (job_valid) begin
          state_next = (cmd == CMD_TICK) ? S_TRD : S_EXEC;
        end
      end
      S_EXEC: state_next = S_FIN;
      S_TRD:  state_next = S_TUPD;
      S_TUPD: begin
        state_next = (idx == TIDX_W'(NUM_TIMERS - 1)) ? S_FIN : S_TRD;
      end
      S_FIN: begin
        if (load_res) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && job_valid) begin
      cmd_q  <= cmd;
      slot_q <= slot;
      dur_q  <= duration;
      hard_q <= hard_stop;
      mask_q <= clear_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      running  <= '0;
      occ_bits <= '0;
      irq_bits <= '0;
      acc_q    <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        status_q[i] <= ST_IDLE;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            idx   <= '0;
            acc_q <= 1'b0;
          end
        end
        S_EXEC: begin
          unique case (cmd_q)
            CMD_SUBMIT: begin
              if (slot_ok) begin
                if (occ_bits[lo_sub]) begin
                  occ_bits[hi_sub] <= 1'b1;
                end else begin
                  occ_bits[lo_sub] <= 1'b1;
                end
                if (!running[t0]) begin
                  running[t0]      <= 1'b1;
                  status_q[slot_q] <= ST_ACTIVE;
                  acc_q            <= 1'b1;
                end else if (!running[t1]) begin
                  running[t1]      <= 1'b1;
                  status_q[slot_q] <= ST_ACTIVE;
                  acc_q            <= 1'b1;
                end
              end
            end
            CMD_STOP: begin
              if (slot_ok) begin
                status_q[slot_q] <= hard_q ? ST_HARD : ST_SOFT;
                running[t0]      <= 1'b0;
                running[t1]      <= 1'b0;
                occ_bits[lo_sub] <= 1'b0;
                occ_bits[hi_sub] <= 1'b0;
                irq_bits[hi_sub] <= 1'b1;
              end
            end
            CMD_CLEAR: irq_bits <= irq_bits & ~mask_q;
            default: ;
          endcase
        end
        S_TUPD: begin
          idx <= idx + TIDX_W'(1);
          if (running[idx] && cd_expired) begin
            running[idx]      <= 1'b0;
            irq_bits[lo_tick] <= 1'b1;
            status_q[tslot]   <= ST_DONE;
            if (occ_bits[lo_tick] && occ_bits[hi_tick]) begin
              occ_bits[hi_tick] <= 1'b0;
            end else if (occ_bits[lo_tick]) begin
              occ_bits[lo_tick] <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      irq_pending <= irq_bits;
      occupancy   <= occ_bits;
      slot_status <= slot_ok ? status_q[slot_q] : ST_IDLE;
      accepted    <= acc_q;
    end
  end

endmodule

`default_nettype wire

[sv/jstm_checker.sv]
// Port-level checker for the job slot timer manager and its bind statement.
`default_nettype none

module jstm_checker import jstm_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                job_valid,
  input logic                job_ready,
  input logic                res_valid,
  input logic                res_ready,
  input logic [REG_W-1:0]    irq_pending,
  input logic [REG_W-1:0]    occupancy,
  input logic [STATUS_W-1:0] slot_status,
  input logic                accepted
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    job_valid && job_ready |=> !job_ready)
    else $error("Block took a second transaction while the first was in progress.");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(irq_pending) &&
      $stable(occupancy) && $stable(slot_status) && $stable(accepted))
    else $error("Stalled result transaction changed or vanished.");

  a_accept_active: assert property (@(posedge clk) disable iff (rst)
    res_valid && accepted |-> slot_status == ST_ACTIVE && occupancy != '0)
    else $error("Accepted submit without an active slot or occupancy.");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !res_valid && job_ready)
    else $error("Block not empty and ready after reset.");

endmodule

bind job_slot_timer_manager jstm_checker u_jstm_checker (.*);

`default_nettype wire

[tb/job_slot_timer_manager_tb.sv]
// Self-checking testbench for the job slot timer manager, with a scoreboard class.
`default_nettype none

module job_slot_timer_manager_tb import jstm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int RANDOM_COMMANDS = 1350;
  localparam int IDLE_PCT        = 22;
  localparam int DRAIN_CYCLES    = 2 * NUM_TIMERS + 4;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_W'(CMD_READ + 1);
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = '1;

  typedef struct packed {
    logic [CMD_W-1:0]  code;
    logic [SLOT_W-1:0] slot;
    logic [DUR_W-1:0]  duration;
    logic              hard;
    logic [REG_W-1:0]  mask;
  } command_t;

  typedef struct packed {
    logic [REG_W-1:0]    irq;
    logic [REG_W-1:0]    occ;
    logic [STATUS_W-1:0] status;
    logic                acc;
  } slot_view_t;

  class slot_timer_scoreboard;
    logic [TIMER_BITS-1:0] remaining[NUM_TIMERS];
    bit                    running[NUM_TIMERS];
    logic [REG_W-1:0]      occ_bits;
    logic [REG_W-1:0]      irq_bits;
    status_t               slot_state[NUM_SLOTS];
    slot_view_t            expected_views[$];
    int                    mismatch_count;

    function new();
      foreach (remaining[t]) begin
        remaining[t] = '0;
        running[t]   = 1'b0;
      end
      foreach (slot_state[s]) slot_state[s] = ST_IDLE;
      occ_bits       = '0;
      irq_bits       = '0;
      mismatch_count = 0;
    endfunction

    function void note_command(command_t c);
      int         s;
      int         t;
      bit         in_range;
      slot_view_t v;
      s        = int'(c.slot);
      in_range = s < NUM_SLOTS;
      v.acc    = 1'b0;
      case (c.code)
        CMD_TICK: begin
          for (t = 0; t < NUM_TIMERS; t++) begin
            if (running[t]) begin
              if (remaining[t] <= 1) begin
                remaining[t] = '0;
                running[t]   = 1'b0;
                s = t / TIMERS_PER_SLOT;
                irq_bits[s]   = 1'b1;
                slot_state[s] = ST_DONE;
                if (occ_bits[s] && occ_bits[s+HI_OFS]) occ_bits[s+HI_OFS] = 1'b0;
                else if (occ_bits[s]) occ_bits[s] = 1'b0;
              end else begin
                remaining[t] = remaining[t] - 1;
              end
            end
          end
          s = int'(c.slot);
        end
        CMD_SUBMIT: begin
          if (in_range) begin
            if (!occ_bits[s]) occ_bits[s] = 1'b1;
            else occ_bits[s+HI_OFS] = 1'b1;
            for (t = s * TIMERS_PER_SLOT; t < (s + 1) * TIMERS_PER_SLOT; t++) begin
              if (!v.acc && !running[t]) begin
                running[t]    = 1'b1;
                remaining[t]  = c.duration;
                slot_state[s] = ST_ACTIVE;
                v.acc         = 1'b1;
              end
            end
          end
        end
        CMD_STOP: begin
          if (in_range) begin
            slot_state[s] = c.hard ? ST_HARD : ST_SOFT;
            for (t = s * TIMERS_PER_SLOT; t < (s + 1) * TIMERS_PER_SLOT; t++) begin
              running[t]   = 1'b0;
              remaining[t] = '0;
            end
            occ_bits[s]        = 1'b0;
            occ_bits[s+HI_OFS] = 1'b0;
            irq_bits[s+HI_OFS] = 1'b1;
          end
        end
        CMD_CLEAR: irq_bits = irq_bits & ~c.mask;
        default: ;
      endcase
      v.irq    = irq_bits;
      v.occ    = occ_bits;
      v.status = in_range ? slot_state[s] : ST_IDLE;
      expected_views.push_back(v);
    endfunction

    task report(string field, logic [REG_W-1:0] got, logic [REG_W-1:0] want);
      $display("%0t ns: %s mismatch, got %h, want %h", $realtime, field, got, want);
      mismatch_count++;
    endtask

    task check_view(slot_view_t got);
      slot_view_t want;
      if (expected_views.size() == 0) begin
        report("unexpected result", got.irq, '0);
      end else begin
        want = expected_views.pop_front();
        if (got.irq !== want.irq) report("irq_pending", got.irq, want.irq);
        if (got.occ !== want.occ) report("occupancy", got.occ, want.occ);
        if (got.status !== want.status) begin
          report("slot_status", REG_W'(got.status), REG_W'(want.status));
        end
        if (got.acc !== want.acc) report("accepted", REG_W'(got.acc), REG_W'(want.acc));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                job_valid;
  logic                job_ready;
  logic [CMD_W-1:0]    cmd;
  logic [SLOT_W-1:0]   slot;
  logic [DUR_W-1:0]    duration;
  logic                hard_stop;
  logic [REG_W-1:0]    clear_mask;
  logic                res_valid;
  logic                res_ready;
  logic [REG_W-1:0]    irq_pending;
  logic [REG_W-1:0]    occupancy;
  logic [STATUS_W-1:0] slot_status;
  logic                accepted;

  int send_idle_pct = IDLE_PCT;
  int take_idle_pct = IDLE_PCT;
  int cycle_count;

  slot_timer_scoreboard board = new();

  job_slot_timer_manager dut (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .cmd         (cmd),
    .slot        (slot),
    .duration    (duration),
    .hard_stop   (hard_stop),
    .clear_mask  (clear_mask),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .irq_pending (irq_pending),
    .occupancy   (occupancy),
    .slot_status (slot_status),
    .accepted    (accepted)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        board.check_view('{irq: irq_pending, occ: occupancy, status: slot_status,
                           acc: accepted});
      end
      res_ready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  task automatic issue_command(command_t c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      job_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    job_valid  <= 1'b1;
    cmd        <= c.code;
    slot       <= c.slot;
    duration   <= c.duration;
    hard_stop  <= c.hard;
    clear_mask <= c.mask;
    do @(posedge clk); while (!job_ready);
    board.note_command(c);
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("job_slot_timer_manager_tb: errors");
    $finish;
  end

  initial begin
    command_t c;
    int       pick;
    int       roll;
    rst        <= 1'b1;
    job_valid  <= 1'b0;
    cmd        <= CMD_READ;
    slot       <= '0;
    duration   <= '0;
    hard_stop  <= 1'b0;
    clear_mask <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    issue_command('{CMD_READ,   4'd0,  32'd0,        1'b0, 32'd0});
    issue_command('{CMD_TICK,   4'd0,  32'd0,        1'b0, 32'd0});
    issue_command('{CMD_SUBMIT, 4'd0,  32'd0,        1'b0, 32'd0});
    issue_command('{CMD_SUBMIT, 4'd0,  32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF});
    issue_command('{CMD_SUBMIT, 4'd0,  32'd3,        1'b0, 32'd0});
    issue_command('{CMD_TICK,   4'd0,  32'd0,        1'b0, 32'd0});
    issue_command('{CMD_SUBMIT, 4'd0,  32'd2,        1'b0, 32'd0});
    issue_command('{CMD_SUBMIT, 4'd15, 32'd1,        1'b0, 32'd0});
    issue_command('{CMD_SUBMIT, 4'd15, 32'd1,        1'b0, 32'd0});
    issue_command('{CMD_SUBMIT, 4'd8,  32'hFFFFFFFF, 1'b0, 32'd0});
    issue_command('{CMD_TICK,   4'd15, 32'd0,        1'b0, 32'd0});
    issue_command('{CMD_READ,   4'd15, 32'd0,        1'b0, 32'd0});
    issue_command('{CMD_TICK,   4'd0,  32'd0,        1'b0, 32'd0});
    issue_command('{CMD_TICK,   4'd0,  32'd0,        1'b0, 32'd0});
    issue_command('{CMD_STOP,   4'd0,  32'd0,        1'b0, 32'd0});
    issue_command('{CMD_STOP,   4'd8,  32'd0,        1'b1, 32'd0});
    issue_command('{CMD_STOP,   4'd7,  32'd0,        1'b1, 32'd0});
    issue_command('{CMD_CLEAR,  4'd0,  32'd0,        1'b0, 32'h00000001});
    issue_command('{CMD_CLEAR,  4'd0,  32'd0,        1'b0, 32'd0});
    issue_command('{CMD_CLEAR,  4'd0,  32'd0,        1'b0, 32'hFFFFFFFF});
    for (int code = CMD_SPARE_LO; code <= CMD_SPARE_HI; code++) begin
      issue_command('{code[CMD_W-1:0], 4'd8, 32'd0, 1'b0, 32'd0});
    end

    for (int n = 0; n < RANDOM_COMMANDS; n++) begin
      send_idle_pct = (n >= 500 && n < 700) ? 0 : IDLE_PCT;
      take_idle_pct = send_idle_pct;
      pick = $urandom_range(99);
      if (pick < 35) c.code = CMD_TICK;
      else if (pick < 65) c.code = CMD_SUBMIT;
      else if (pick < 73) c.code = CMD_STOP;
      else if (pick < 85) c.code = CMD_CLEAR;
      else if (pick < 96) c.code = CMD_READ;
      else c.code = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
      c.slot = $urandom_range(1) ? SLOT_W'($urandom_range(3))
                                 : SLOT_W'($urandom_range(NUM_SLOTS - 1));
      roll = $urandom_range(99);
      if (roll < 70) c.duration = $urandom_range(6);
      else if (roll < 88) c.duration = $urandom_range(40);
      else if (roll < 95) c.duration = $urandom;
      else c.duration = '1;
      c.hard = 1'($urandom_range(1));
      roll = $urandom_range(99);
      if (roll < 50) c.mask = $urandom;
      else if (roll < 90) c.mask = 32'd1 << $urandom_range(REG_W - 1);
      else c.mask = '1;
      issue_command(c);
    end
    job_valid <= 1'b0;

    while (board.expected_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatch_count == 0) $display("job_slot_timer_manager_tb: clean");
    else $display("job_slot_timer_manager_tb: errors");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
sv/jstm_pkg.sv
sv/jstm_timer_ram.sv
sv/jstm_countdown.sv
sv/job_slot_timer_manager.sv
sv/jstm_checker.sv
tb/job_slot_timer_manager_tb.sv
